>>> src/msi_pkg.sv
// Shared constants, codes and types of the MSI line controller.
package msi_pkg;

  localparam int LINES  = 1024;
  localparam int LINE_W = $clog2(LINES);
  localparam int CMD_W  = 3;
  localparam int IDX_W  = 10;
  localparam int ADDR_W = 32;
  localparam int NODE_W = 6;
  localparam int ACT_W  = 3;
  localparam int ERR_W  = 2;
  localparam int ST_W   = 3;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 3'd0,
    CMD_STORE = 3'd1,
    CMD_GETS  = 3'd2,
    CMD_GETM  = 3'd3,
    CMD_DATA  = 3'd4,
    CMD_INV   = 3'd5,
    CMD_UPG   = 3'd6
  } msi_cmd_t;

  typedef enum logic [ST_W-1:0] {
    LS_I  = 3'd0,
    LS_S  = 3'd1,
    LS_M  = 3'd2,
    LS_IS = 3'd3,
    LS_IM = 3'd4,
    LS_SM = 3'd5
  } msi_line_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE   = 3'd0,
    ACT_GETS   = 3'd1,
    ACT_GETM   = 3'd2,
    ACT_TOPROC = 3'd3,
    ACT_TONODE = 3'd4,
    ACT_INVACK = 3'd5
  } msi_act_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_UNEXP = 2'd1,
    ERR_OUTST = 2'd2
  } msi_err_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } msi_bk_state_t;

  // Classified word passed from front to back.
  typedef struct packed {
    msi_cmd_t          cmd;
    logic              is_proc;
    logic [LINE_W-1:0] line;
    logic [ADDR_W-1:0] addr;
    logic [NODE_W-1:0] src;
  } msi_item_t;

endpackage

>>> src/msi_if.sv
// Valid/ready channel interfaces for input and result words.
interface msi_in_if;
  import msi_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [IDX_W-1:0]  line_index;
  logic [ADDR_W-1:0] address;
  logic [NODE_W-1:0] source_node;

  modport source (output valid, command, line_index, address, source_node, input ready);
  modport sink   (input valid, command, line_index, address, source_node, output ready);
endinterface

interface msi_out_if;
  import msi_pkg::*;
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [ADDR_W-1:0] out_address;
  logic [NODE_W-1:0] dest_node;
  logic              was_miss;
  logic              was_transfer;
  logic [ERR_W-1:0]  error_code;

  modport source (output valid, action, out_address, dest_node, was_miss, was_transfer,
                  error_code, input ready);
  modport sink   (input valid, action, out_address, dest_node, was_miss, was_transfer,
                  error_code, output ready);
endinterface

>>> src/msi_coherence_line_controller_core.sv
// Top level of the MSI coherence line controller.
//
//   port     dir   role                   payload
//   in_ch    sink  load/store/net word    command, line_index, address, source_node
//   out_ch   src   one result per word    action, out_address, dest_node, was_miss,
//                                         was_transfer, error_code
//
// Each word passes two back-end steps: a read of its line state from the
// table, then a write of the new state and a load of the result register;
// the back end takes the next word only once the last one is written.
// After reset a clearing pass sets all 1024 lines to I with in_ch.ready low.
// A two-word queue lets input be taken while a result waits; a stalled
// result holds the back end in its write step.
module msi_coherence_line_controller_core (
  input  logic       clk,
  input  logic       rst_n,
  msi_in_if.sink     in_ch,
  msi_out_if.source  out_ch
);
  import msi_pkg::*;

  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_valid;
  logic      bk_clearing;
  msi_item_t q_item;
  msi_item_t q_head;

  msi_front u_front (
    .in_ch       (in_ch),
    .bk_clearing (bk_clearing),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (q_item)
  );

  msi_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head       (q_head)
  );

  msi_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .bk_clearing (bk_clearing),
    .out_ch      (out_ch)
  );

endmodule

>>> src/msi_front.sv
// Front end: accept input words and classify them for the back end.
module msi_front (
  msi_in_if.sink              in_ch,
  input  logic                bk_clearing,
  input  logic                q_full,
  output logic                q_push,
  output msi_pkg::msi_item_t  q_item
);
  import msi_pkg::*;

  msi_cmd_t cmd;

  assign in_ch.ready = !bk_clearing && !q_full;
  assign q_push      = in_ch.valid && in_ch.ready;
  assign cmd         = msi_cmd_t'(in_ch.command);

  always_comb begin
    q_item.cmd     = cmd;
    q_item.is_proc = (cmd == CMD_LOAD) || (cmd == CMD_STORE);
    // line index wraps on the table size
    q_item.line    = in_ch.line_index[LINE_W-1:0];
    q_item.addr    = in_ch.address;
    q_item.src     = in_ch.source_node;
  end

endmodule

>>> src/msi_queue.sv
// Short FIFO that decouples the front end from the back end.
module msi_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  msi_pkg::msi_item_t  push_item,
  input  logic                pop,
  output logic                full,
  output logic                head_valid,
  output msi_pkg::msi_item_t  head
);
  import msi_pkg::*;

  msi_item_t         entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head       = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> src/msi_back.sv
// Back end: line state table, clearing pass, MSI transitions, result register.
module msi_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  msi_pkg::msi_item_t  q_head,
  output logic                q_pop,
  output logic                bk_clearing,
  msi_out_if.source           out_ch
);
  import msi_pkg::*;

  logic [ST_W-1:0]   mem [LINES];
  logic [ST_W-1:0]   rd_data_r;
  logic [LINE_W-1:0] rd_addr;
  logic [LINE_W-1:0] wr_addr;
  logic [ST_W-1:0]   wr_data;
  logic              mem_we;

  msi_bk_state_t     state_r, state_nxt;
  logic [LINE_W-1:0] clr_cnt_r, clr_cnt_nxt;
  msi_item_t         work_r;
  logic              out_free;
  logic              out_load;

  msi_line_t cur_st, next_st;
  msi_act_t  act;
  msi_err_t  err;
  logic      miss;

  logic              out_valid_r;
  logic [ACT_W-1:0]  act_r;
  logic [ADDR_W-1:0] addr_r;
  logic [NODE_W-1:0] dest_r;
  logic              miss_r;
  logic              xfer_r;
  logic [ERR_W-1:0]  err_r;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign bk_clearing = (state_r == BK_CLEAR);
  assign cur_st      = msi_line_t'(rd_data_r);

  // next state
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      BK_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LINE_W'(LINES - 1)) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid) begin
          state_nxt = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop    = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    rd_addr  = work_r.line;
    wr_addr  = work_r.line;
    wr_data  = next_st;
    case (state_r)
      BK_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = clr_cnt_r;
        wr_data = LS_I;
      end
      BK_IDLE: begin
        q_pop   = q_valid;
        rd_addr = q_head.line;
      end
      BK_EXEC: begin
        mem_we   = out_free;
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // protocol transitions
  always_comb begin
    next_st = cur_st;
    act     = ACT_NONE;
    err     = ERR_OK;
    miss    = 1'b0;
    case (cur_st)
      LS_I: begin
        if (work_r.cmd == CMD_LOAD) begin
          act = ACT_GETS; next_st = LS_IS; miss = 1'b1;
        end else if (work_r.cmd == CMD_STORE) begin
          act = ACT_GETM; next_st = LS_IM; miss = 1'b1;
        end else begin
          err = ERR_UNEXP;
        end
      end
      LS_S: begin
        if (work_r.cmd == CMD_LOAD) begin
          act = ACT_TOPROC;
        end else if (work_r.cmd == CMD_STORE) begin
          act = ACT_GETM; next_st = LS_SM;
        end else if (work_r.cmd == CMD_INV) begin
          act = ACT_INVACK; next_st = LS_I;
        end else begin
          err = ERR_UNEXP;
        end
      end
      LS_M: begin
        if (work_r.is_proc) begin
          act = ACT_TOPROC;
        end else if (work_r.cmd == CMD_GETS) begin
          act = ACT_TONODE; next_st = LS_S;
        end else if (work_r.cmd == CMD_GETM || work_r.cmd == CMD_INV) begin
          act = ACT_TONODE; next_st = LS_I;
        end else begin
          err = ERR_UNEXP;
        end
      end
      LS_IS, LS_IM, LS_SM: begin
        if (work_r.is_proc) begin
          err = ERR_OUTST;
        end else if (cur_st == LS_IS && work_r.cmd == CMD_DATA) begin
          act = ACT_TOPROC; next_st = LS_S;
        end else if (cur_st == LS_IM && work_r.cmd == CMD_DATA) begin
          act = ACT_TOPROC; next_st = LS_M;
        end else if (cur_st == LS_SM && work_r.cmd == CMD_INV) begin
          act = ACT_INVACK; next_st = LS_IM;
        end else if (cur_st == LS_SM && work_r.cmd == CMD_UPG) begin
          act = ACT_TOPROC; next_st = LS_M;
        end else begin
          err = ERR_UNEXP;
        end
      end
      default: err = ERR_UNEXP;
    endcase
  end

  // table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      work_r <= q_head;
    end
    if (out_load) begin
      act_r  <= act;
      addr_r <= (act != ACT_NONE) ? work_r.addr : '0;
      dest_r <= (act == ACT_TONODE) ? work_r.src : '0;
      miss_r <= miss;
      xfer_r <= (act == ACT_TONODE);
      err_r  <= err;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.action       = act_r;
  assign out_ch.out_address  = addr_r;
  assign out_ch.dest_node    = dest_r;
  assign out_ch.was_miss     = miss_r;
  assign out_ch.was_transfer = xfer_r;
  assign out_ch.error_code   = err_r;

endmodule

>>> tb/msi_line_checker.sv
// Checker for the MSI line controller: tracks line states, predicts each result and compares.
module msi_line_checker (
  input  logic clk,
  input  logic rst_n,
  msi_in_if    in_mon,
  msi_out_if   out_mon,
  output int   fail_count,
  output int   n_waiting
);
  import msi_pkg::*;

  typedef struct packed {
    msi_act_t          act;
    logic [ADDR_W-1:0] addr;
    logic [NODE_W-1:0] dest;
    logic              miss;
    logic              xfer;
    msi_err_t          err;
  } line_result_t;

  msi_line_t    line_tbl [LINES];
  line_result_t pending_results [$];

  initial begin
    fail_count = 0;
    n_waiting  = 0;
  end

  // Work out the result of one word and the next state of its line.
  function automatic line_result_t line_step(input logic [CMD_W-1:0] cmd,
                                             input logic [ADDR_W-1:0] addr,
                                             input logic [NODE_W-1:0] src,
                                             input msi_line_t st,
                                             output msi_line_t nxt);
    line_result_t r;
    logic         is_proc;
    r       = '0;
    r.act   = ACT_NONE;
    r.err   = ERR_OK;
    nxt     = st;
    is_proc = (cmd == CMD_LOAD) || (cmd == CMD_STORE);
    case (st)
      LS_I: begin
        if (cmd == CMD_LOAD) begin
          r.act = ACT_GETS; nxt = LS_IS; r.miss = 1'b1;
        end else if (cmd == CMD_STORE) begin
          r.act = ACT_GETM; nxt = LS_IM; r.miss = 1'b1;
        end else begin
          r.err = ERR_UNEXP;
        end
      end
      LS_S: begin
        if (cmd == CMD_LOAD) begin
          r.act = ACT_TOPROC;
        end else if (cmd == CMD_STORE) begin
          r.act = ACT_GETM; nxt = LS_SM;
        end else if (cmd == CMD_INV) begin
          r.act = ACT_INVACK; nxt = LS_I;
        end else begin
          r.err = ERR_UNEXP;
        end
      end
      LS_M: begin
        if (is_proc) begin
          r.act = ACT_TOPROC;
        end else if (cmd == CMD_GETS) begin
          r.act = ACT_TONODE; nxt = LS_S;
        end else if (cmd == CMD_GETM || cmd == CMD_INV) begin
          r.act = ACT_TONODE; nxt = LS_I;
        end else begin
          r.err = ERR_UNEXP;
        end
      end
      LS_IS, LS_IM, LS_SM: begin
        if (is_proc) begin
          r.err = ERR_OUTST;
        end else if (st == LS_IS && cmd == CMD_DATA) begin
          r.act = ACT_TOPROC; nxt = LS_S;
        end else if (st == LS_IM && cmd == CMD_DATA) begin
          r.act = ACT_TOPROC; nxt = LS_M;
        end else if (st == LS_SM && cmd == CMD_INV) begin
          r.act = ACT_INVACK; nxt = LS_IM;
        end else if (st == LS_SM && cmd == CMD_UPG) begin
          r.act = ACT_TOPROC; nxt = LS_M;
        end else begin
          r.err = ERR_UNEXP;
        end
      end
      default: r.err = ERR_UNEXP;
    endcase
    // address and node only travel with a real message
    if (r.act != ACT_NONE) r.addr = addr;
    if (r.act == ACT_TONODE) begin
      r.dest = src;
      r.xfer = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    line_result_t got;
    line_result_t want;
    msi_line_t    nxt;
    int unsigned  ln;
    if (!rst_n) begin
      foreach (line_tbl[i]) line_tbl[i] = LS_I;
      pending_results.delete();
    end else begin
      // retire the oldest expectation before adding this edge's word
      if (out_mon.valid && out_mon.ready) begin
        got.act  = msi_act_t'(out_mon.action);
        got.addr = out_mon.out_address;
        got.dest = out_mon.dest_node;
        got.miss = out_mon.was_miss;
        got.xfer = out_mon.was_transfer;
        got.err  = msi_err_t'(out_mon.error_code);
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result act=%0d addr=%h dest=%0d miss=%b xfer=%b err=%0d",
                   $time, got.act, got.addr, got.dest, got.miss, got.xfer, got.err);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: mismatch expected act=%0d addr=%h dest=%0d miss=%b xfer=%b err=%0d",
                     $time, want.act, want.addr, want.dest, want.miss, want.xfer, want.err);
            $display("%0t:          actual   act=%0d addr=%h dest=%0d miss=%b xfer=%b err=%0d",
                     $time, got.act, got.addr, got.dest, got.miss, got.xfer, got.err);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        ln   = in_mon.line_index % LINES;
        want = line_step(in_mon.command, in_mon.address, in_mon.source_node,
                         line_tbl[ln], nxt);
        line_tbl[ln] = nxt;
        pending_results.push_back(want);
      end
    end
    n_waiting = pending_results.size();
  end

endmodule

>>> tb/tb_top.sv
// Top of the MSI line controller testbench: clock, reset, word traffic and verdict.
module tb_top;
  import msi_pkg::*;

  localparam int HOLD_LEN   = 200;
  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_WAIT  = 20;
  localparam int HOT_LINES  = 16;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   n_waiting;
  int   words_sent;
  int   send_idle_pct;
  int   stall_pct;
  int   hold_req;
  int   hold_ack;
  int   hold_left;
  int   quiet_cycles;

  msi_in_if  in_ch ();
  msi_out_if out_ch ();

  msi_coherence_line_controller_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  msi_line_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .n_waiting  (n_waiting)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    = hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack     = hold_req;
      hold_left    = HOLD_LEN - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("msi_coherence_line_controller_core test failed");
        $finish;
      end
    end
  end

  // Offer one word, after random idle cycles; return at the negedge after it is taken.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                           input logic [ADDR_W-1:0] addr, input logic [NODE_W-1:0] src);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.line_index  <= idx;
    in_ch.address     <= addr;
    in_ch.source_node <= src;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // Stop offering and hold until every expected result is back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (n_waiting != 0) @(negedge clk);
  endtask

  function automatic logic [IDX_W-1:0] pick_line();
    if ($urandom_range(0, 99) < 70)
      return IDX_W'($urandom_range(0, HOT_LINES - 1));
    return IDX_W'($urandom_range(0, LINES - 1));
  endfunction

  function automatic logic [NODE_W-1:0] pick_node();
    return NODE_W'($urandom_range(0, (1 << NODE_W) - 1));
  endfunction

  // One short transaction on a line, mostly well-formed, sometimes noise.
  task automatic gen_burst();
    logic [IDX_W-1:0]  ln;
    logic [ADDR_W-1:0] a;
    int                kind;
    int                pick;
    ln   = pick_line();
    a    = $urandom();
    kind = $urandom_range(0, 9);
    pick = $urandom_range(0, 2);
    case (kind)
      0, 1: begin
        send_word(CMD_LOAD, ln, a, pick_node());
        send_word(CMD_DATA, ln, a, pick_node());
        send_word(CMD_LOAD, ln, a, pick_node());
        send_word(CMD_INV, ln, a, pick_node());
      end
      2, 3: begin
        send_word(CMD_STORE, ln, a, pick_node());
        send_word(CMD_DATA, ln, a, pick_node());
        send_word(($urandom_range(0, 1) != 0) ? CMD_STORE : CMD_LOAD, ln, a, pick_node());
        send_word((pick == 0) ? CMD_GETS : (pick == 1) ? CMD_GETM : CMD_INV,
                  ln, a, pick_node());
      end
      4, 5: begin
        send_word(CMD_LOAD, ln, a, pick_node());
        send_word(CMD_DATA, ln, a, pick_node());
        send_word(CMD_STORE, ln, a, pick_node());
        if (pick == 0) begin
          send_word(CMD_INV, ln, a, pick_node());
          send_word(CMD_DATA, ln, a, pick_node());
        end else begin
          send_word(CMD_UPG, ln, a, pick_node());
        end
      end
      6: begin
        send_word(($urandom_range(0, 1) != 0) ? CMD_STORE : CMD_LOAD, ln, a, pick_node());
        send_word(CMD_W'($urandom_range(CMD_GETS, CMD_UNUSED)), ln, a, pick_node());
      end
      default: send_word(CMD_W'($urandom_range(0, CMD_UNUSED)), ln, a, pick_node());
    endcase
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int n_words);
    int goal;
    goal          = words_sent + n_words;
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    while (words_sent < goal) gen_burst();
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_LOAD;
    in_ch.line_index  = '0;
    in_ch.address     = '0;
    in_ch.source_node = '0;
    out_ch.ready      = 1'b0;
    words_sent        = 0;
    send_idle_pct     = 0;
    stall_pct         = 0;
    hold_req          = 0;
    hold_ack          = 0;
    hold_left         = 0;
    quiet_cycles      = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // walk line 0 through every stable and transient state
    send_word(CMD_LOAD,   10'd0, 32'h0000_0000, 6'd0);
    send_word(CMD_STORE,  10'd0, 32'h0000_0000, 6'd0);
    send_word(CMD_GETS,   10'd0, 32'hFFFF_FFFF, 6'd63);
    send_word(CMD_DATA,   10'd0, 32'hFFFF_FFFF, 6'd63);
    send_word(CMD_LOAD,   10'd0, 32'hFFFF_FFFF, 6'd0);
    send_word(CMD_GETM,   10'd0, 32'h0000_0000, 6'd63);
    send_word(CMD_STORE,  10'd0, 32'hFFFF_FFFF, 6'd63);
    send_word(CMD_LOAD,   10'd0, 32'h0000_0000, 6'd0);
    send_word(CMD_DATA,   10'd0, 32'hFFFF_FFFF, 6'd0);
    send_word(CMD_INV,    10'd0, 32'hFFFF_FFFF, 6'd63);
    send_word(CMD_DATA,   10'd0, 32'h0000_0000, 6'd63);
    send_word(CMD_UPG,    10'd0, 32'hFFFF_FFFF, 6'd0);
    send_word(CMD_GETS,   10'd0, 32'hFFFF_FFFF, 6'd63);
    send_word(CMD_STORE,  10'd0, 32'h0000_0000, 6'd0);
    send_word(CMD_UPG,    10'd0, 32'hFFFF_FFFF, 6'd63);
    send_word(CMD_STORE,  10'd0, 32'h0000_0000, 6'd63);
    send_word(CMD_GETM,   10'd0, 32'hFFFF_FFFF, 6'd0);
    send_word(CMD_UNUSED, 10'd0, 32'hFFFF_FFFF, 6'd63);
    send_word(CMD_INV,    10'd0, 32'h0000_0000, 6'd63);
    // top line, with an invalidate taking modified data away
    send_word(CMD_STORE,  10'd1023, 32'hFFFF_FFFF, 6'd63);
    send_word(CMD_UPG,    10'd1023, 32'h0000_0000, 6'd63);
    send_word(CMD_DATA,   10'd1023, 32'hFFFF_FFFF, 6'd0);
    send_word(CMD_INV,    10'd1023, 32'hFFFF_FFFF, 6'd63);
    send_word(CMD_LOAD,   10'd1023, 32'hFFFF_FFFF, 6'd63);
    send_word(CMD_UNUSED, 10'd1023, 32'h0000_0000, 6'd0);
    drain();

    run_phase(0, 0, 250);
    // hold the result side long enough for the input to back up
    hold_req = hold_req + 1;
    run_phase(0, 0, 250);
    drain();
    run_phase(55, 0, 500);
    run_phase(0, 55, 500);
    drain();
    run_phase(17, 17, 500);

    drain();
    repeat (TAIL_WAIT) @(negedge clk);
    if (fail_count == 0)
      $display("msi_coherence_line_controller_core test passed");
    else
      $display("msi_coherence_line_controller_core test failed");
    $finish;
  end

endmodule

>>> filelist.f
src/msi_pkg.sv
src/msi_if.sv
src/msi_front.sv
src/msi_queue.sv
src/msi_back.sv
src/msi_coherence_line_controller_core.sv
tb/msi_line_checker.sv
tb/tb_top.sv
